@@ rtl/hcbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hcbe_pkg;

	// default width of the chunk size counters
	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CR_CHAR = 8'h0D;
	localparam logic [7:0] LF_CHAR = 8'h0A;

endpackage
`default_nettype wire

@@ rtl/hcbe_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hcbe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

@@ rtl/hcbe_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hcbe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;

	modport source (output valid, output out_byte, output is_last, input ready);
	modport sink (input valid, input out_byte, input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/hcbe_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hcbe_cfg_if;
	logic valid;
	logic ready;
	logic chunked_mode;

	modport source (output valid, output chunked_mode, input ready);
	modport sink (input valid, input chunked_mode, output ready);
endinterface
`default_nettype wire

@@ rtl/http_chunked_body_extractor.sv @@
// http response body extractor
// rx carries one response byte per item (in_byte), or an end_of_input
// item that marks the connection as closed and carries no byte
// tx carries the body bytes; any final item is a newline with is_last set
// cfg writes chunked_mode: 0 passes the body as is, 1 decodes chunked
// framing; the mode is sampled when the header terminator is seen, so
// write it while the block is idle, before the response starts
// every rx item is handled in the cycle it is accepted and its result, if
// any, sits in the tx output register from the next cycle; throughput is
// one item per cycle unless tx stalls: the per-byte state update is a
// single hex accumulate or down count between the rx handshake and the tx
// register; when tx stalls, rx ready follows tx ready, since the output
// register is the only storage for a pending result; no item is dropped
// or repeated; after a last newline (or end in chunked mode) all items are
// swallowed until reset; reset clears the mode, the phase and tx valid
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_body_extractor #(
	parameter int SIZE_BITS = hcbe_pkg::SIZE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	hcbe_in_if.sink     rx,
	hcbe_out_if.source  tx,
	hcbe_cfg_if.sink    cfg
);
	import hcbe_pkg::*;

	// decoder phases
	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_PLAIN   = 3'd1;
	localparam logic [2:0] PH_SIZE    = 3'd2;
	localparam logic [2:0] PH_DATA    = 3'd3;
	localparam logic [2:0] PH_TRAILER = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	// hex character decode, bit 4 flags a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		end
		return r;
	endfunction

	logic                 mode_q;
	logic [2:0]           phase_q, phase_d;
	logic [1:0]           match_q, match_d;
	logic [SIZE_BITS-1:0] chunk_len_q, chunk_len_d;
	logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;
	logic                 digits_seen_q, digits_seen_d;
	logic                 digits_ended_q, digits_ended_d;
	logic                 cr_seen_q, cr_seen_d;
	logic                 trailer_q, trailer_d;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 is_last_q;

	logic                 accept;
	logic                 emit;
	logic [7:0]           emit_byte;
	logic                 emit_last;

	logic [4:0]           hex;
	logic [SIZE_BITS+3:0] grown;
	logic [SIZE_BITS-1:0] left_dec;
	logic [7:0]           expect_char;

	// output register frees up when it is empty or being taken
	assign rx.ready  = !out_valid_q || tx.ready;
	assign accept    = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	assign tx.valid    = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.is_last  = is_last_q;

	assign hex         = hex_decode(rx.in_byte);
	// size * 16 + digit, carry bits above the size width mean saturation
	assign grown       = {chunk_len_q, 4'b0000} + {SIZE_BITS'(0), hex[3:0]};
	assign left_dec    = bytes_left_q - SIZE_BITS'(1);
	// terminator alternates CR, LF
	assign expect_char = match_q[0] ? LF_CHAR : CR_CHAR;

	always_comb begin
		phase_d        = phase_q;
		match_d        = match_q;
		chunk_len_d    = chunk_len_q;
		bytes_left_d   = bytes_left_q;
		digits_seen_d  = digits_seen_q;
		digits_ended_d = digits_ended_q;
		cr_seen_d      = cr_seen_q;
		trailer_d      = trailer_q;
		emit           = 1'b0;
		emit_byte      = rx.in_byte;
		emit_last      = 1'b0;

		if (phase_q == PH_DONE) begin
			// swallow everything until reset
		end else if (rx.end_of_input) begin
			phase_d   = PH_DONE;
			emit_byte = LF_CHAR;
			emit_last = 1'b1;
			emit      = (phase_q == PH_PLAIN) || (phase_q == PH_HEADER && !mode_q);
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (rx.in_byte == expect_char) begin
						match_d = match_q + 2'd1;
						if (match_q == 2'd3) begin
							if (mode_q) begin
								phase_d        = PH_SIZE;
								chunk_len_d    = '0;
								digits_seen_d  = 1'b0;
								digits_ended_d = 1'b0;
								cr_seen_d      = 1'b0;
							end else begin
								phase_d = PH_PLAIN;
							end
						end
					end else begin
						match_d = (rx.in_byte == CR_CHAR) ? 2'd1 : 2'd0;
					end
				end
				PH_PLAIN: begin
					emit = 1'b1;
				end
				PH_SIZE: begin
					if (cr_seen_q && rx.in_byte == LF_CHAR) begin
						// end of size line: zero size or no digit ends the body
						if (!digits_seen_q || chunk_len_q == '0) begin
							phase_d   = PH_DONE;
							emit      = 1'b1;
							emit_byte = LF_CHAR;
							emit_last = 1'b1;
						end else begin
							bytes_left_d = chunk_len_q;
							phase_d      = PH_DATA;
						end
					end else begin
						cr_seen_d = (rx.in_byte == CR_CHAR);
						if (!digits_ended_q) begin
							if (hex[4]) begin
								if (grown[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
									chunk_len_d = '1;
								end else begin
									chunk_len_d = grown[SIZE_BITS-1:0];
								end
								digits_seen_d = 1'b1;
							end else begin
								// anything after the digits is an extension, ignored
								digits_ended_d = 1'b1;
							end
						end
					end
				end
				PH_DATA: begin
					emit         = 1'b1;
					bytes_left_d = left_dec;
					if (left_dec == '0) begin
						phase_d   = PH_TRAILER;
						trailer_d = 1'b0;
					end
				end
				PH_TRAILER: begin
					// two bytes after the data are skipped unchecked
					trailer_d = 1'b1;
					if (trailer_q) begin
						trailer_d      = 1'b0;
						phase_d        = PH_SIZE;
						chunk_len_d    = '0;
						digits_seen_d  = 1'b0;
						digits_ended_d = 1'b0;
						cr_seen_d      = 1'b0;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			phase_q        <= PH_HEADER;
			match_q        <= 2'd0;
			chunk_len_q    <= '0;
			bytes_left_q   <= '0;
			digits_seen_q  <= 1'b0;
			digits_ended_q <= 1'b0;
			cr_seen_q      <= 1'b0;
			trailer_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.chunked_mode;
			end
			if (accept) begin
				phase_q        <= phase_d;
				match_q        <= match_d;
				chunk_len_q    <= chunk_len_d;
				bytes_left_q   <= bytes_left_d;
				digits_seen_q  <= digits_seen_d;
				digits_ended_q <= digits_ended_d;
				cr_seen_q      <= cr_seen_d;
				trailer_q      <= trailer_d;
				out_valid_q    <= emit;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only with a new result
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_byte_q <= emit_byte;
			is_last_q  <= emit_last;
		end
	end

endmodule
`default_nettype wire

@@ rtl/hcbe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hcbe_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       rx_valid,
	input wire       rx_ready,
	input wire       tx_valid,
	input wire       tx_ready,
	input wire [7:0] tx_out_byte,
	input wire       tx_is_last
);
	import hcbe_pkg::*;

	logic done_q;

	// set once the last item has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (tx_valid && tx_ready && tx_is_last) begin
			done_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte) && $stable(tx_is_last))
		else $error("stalled result changed");

	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_is_last |-> tx_out_byte == LF_CHAR)
		else $error("last item is not a newline");

	a_nothing_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !tx_valid)
		else $error("result after the last item");

	a_result_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tx_valid) |-> $past(rx_valid && rx_ready))
		else $error("result without an accepted input");

endmodule

bind http_chunked_body_extractor hcbe_checker u_hcbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_byte (tx.out_byte),
	.tx_is_last  (tx.is_last)
);
`default_nettype wire
